@@ hw/rtl/ibm_pkg.sv @@
// Shared widths, mark codes and chain record types for the interval break marker.
package ibm_pkg;

    localparam int DEF_MAX_DEGREE = 8;

    localparam int DEGREE_W = 4;
    localparam int CHROM_W  = 8;
    localparam int POS_W    = 32;
    localparam int LABEL_W  = 8;
    localparam int MARK_W   = 2;

    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd4;

    typedef enum logic [MARK_W-1:0] {
        MARK_NONE   = 2'd0,
        MARK_BRK    = 2'd1,
        MARK_BROKEN = 2'd2
    } mark_t;

    // One pending interval as it travels along the cell chain.
    typedef struct packed {
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
        logic [POS_W-1:0]   size;
        logic [LABEL_W-1:0] label;
        logic               last_tag;
        logic               brk;
        logic               brkn;
        logic               valid;
    } ibm_entry_t;

    // What a flanking cell offers to the pair search around the center cell.
    typedef struct packed {
        logic               en;
        logic               big;
        logic [LABEL_W-1:0] label;
    } ibm_flank_t;

    // Per-cell control for one clock edge.
    typedef struct packed {
        logic shift;
        logic load;
        logic pass;
        logic drop;
        logic set_brk;
        logic set_brkn;
    } ibm_cell_ctl_t;

endpackage

@@ hw/rtl/ibm_intf.sv @@
// Valid/ready channel interfaces for intervals, marked results and the degree register.
interface ibm_item_if import ibm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHROM_W-1:0] chrom_id;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
    logic [LABEL_W-1:0] state_label;
    logic               last_item;

    modport source (
        output valid, chrom_id, start_pos, end_pos, state_label, last_item,
        input  ready
    );
    modport sink (
        input  valid, chrom_id, start_pos, end_pos, state_label, last_item,
        output ready
    );
endinterface

interface ibm_result_if import ibm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHROM_W-1:0] out_chrom;
    logic [POS_W-1:0]   out_start;
    logic [POS_W-1:0]   out_end;
    logic [LABEL_W-1:0] out_label;
    mark_t              mark;
    logic               final_result;

    modport source (
        output valid, out_chrom, out_start, out_end, out_label, mark, final_result,
        input  ready
    );
    modport sink (
        input  valid, out_chrom, out_start, out_end, out_label, mark, final_result,
        output ready
    );
endinterface

interface ibm_cfg_if import ibm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DEGREE_W-1:0] degree;

    modport source (
        output valid, degree,
        input  ready
    );
    modport sink (
        input  valid, degree,
        output ready
    );
endinterface

@@ hw/rtl/ibm_cell.sv @@
// One cell of the interval chain: holds one pending interval and its mark flags.
module ibm_cell import ibm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  ibm_cell_ctl_t    ctl,
    input  ibm_entry_t       new_item,
    input  ibm_entry_t       prev_item,
    input  logic [POS_W-1:0] centre_size,
    output ibm_entry_t       cur_item,
    output logic             big
);

    logic       valid_reg;
    logic       valid_next;
    ibm_entry_t data_reg;
    ibm_entry_t data_next;

    // The outgoing view already carries the flags raised in this cycle, so a
    // neighbor that takes it on a shift sees the updated mark.
    always_comb
    begin
        cur_item       = data_reg;
        cur_item.valid = valid_reg;
        cur_item.brk   = data_reg.brk | ctl.set_brk;
        cur_item.brkn  = data_reg.brkn | ctl.set_brkn;
    end

    always_comb
    begin
        if (ctl.shift)
        begin
            data_next  = ctl.load ? new_item : prev_item;
            valid_next = ctl.load ? new_item.valid : (ctl.pass & prev_item.valid);
        end
        else
        begin
            data_next  = cur_item;
            valid_next = valid_reg & ~ctl.drop;
        end
    end

    // Flanking size test: the center is short against this interval.
    assign big = valid_reg && (centre_size < (data_reg.size >> 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ hw/rtl/ibm_judge.sv @@
// Pair search across the center cell: matching labels on both flanks that both dwarf the center.
module ibm_judge import ibm_pkg::*; #(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
    input  ibm_flank_t            left_side  [MAX_DEGREE],
    input  ibm_flank_t            right_side [MAX_DEGREE],
    output logic                  centre_hit,
    output logic [MAX_DEGREE-1:0] left_hit,
    output logic [MAX_DEGREE-1:0] right_hit
);

    logic [MAX_DEGREE-1:0] pair_hit [MAX_DEGREE];

    for (genvar j = 0; j < MAX_DEGREE; j++)
    begin : g_left
        for (genvar k = 0; k < MAX_DEGREE; k++)
        begin : g_right
            assign pair_hit[j][k] = left_side[j].en && left_side[j].big &&
                                    right_side[k].en && right_side[k].big &&
                                    (left_side[j].label == right_side[k].label);
        end
    end

    always_comb
    begin
        left_hit  = '0;
        right_hit = '0;
        for (int j = 0; j < MAX_DEGREE; j++)
        begin
            left_hit[j] = |pair_hit[j];
            right_hit   = right_hit | pair_hit[j];
        end
        centre_hit = |left_hit;
    end

endmodule

@@ hw/rtl/interval_break_marker_unit.sv @@
// Top level of the interval break marker: input stage, cell chain, pair search and result register.
//
// The block takes a stream of labelled intervals, one beat each, and returns every
// interval once, in arrival order, with a mark: none, break or broken. Intervals of one
// region (same chromosome, each starting where the previous one ended) move through a
// row of 2*MAX_DEGREE+1 cells, one cell per accepted beat; a new region's first interval
// enters the row at a distance of degree cells before the fixed center cell, so an
// interval reaches the center exactly when degree newer intervals of its region sit on
// its right. In every cycle the center is tested against all left and right flanks at
// once, and the flanks' size tests and label matches raise the break and broken flags in
// place. An interval leaves the row and is offered as a result once it has served as the
// last left flank it can be, degree cells past the center. While a region streams, one
// interval is accepted per cycle and one result leaves per cycle, limited only by the
// single result register and its consumer. A chromosome change, a gap in coordinates or a
// beat with last_item set ends the region: empty slots are then shifted in, one per cycle
// while the result register can take the leaving interval, until every pending interval
// has been delivered, before the next region's first interval can enter. The degree
// register is sampled when a region's first interval enters; values above MAX_DEGREE
// behave as MAX_DEGREE and a degree of zero passes every interval through unmarked.
// final_result is set on the result beat of the interval that carried last_item. A result
// passes the input stage, the cell row and the result register, and waits behind a stalled output.
module interval_break_marker_unit import ibm_pkg::*; #(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
    input  logic         clk,
    input  logic         rst_n,
    ibm_item_if.sink     item,
    ibm_result_if.source result,
    ibm_cfg_if.sink      cfg
);

    localparam int NCELL = 2 * MAX_DEGREE + 1;
    localparam int DW    = $clog2(MAX_DEGREE + 1);

    // Input holding stage.
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [CHROM_W-1:0] in_chrom_reg;
    logic [POS_W-1:0]   in_start_reg;
    logic [POS_W-1:0]   in_end_reg;
    logic [LABEL_W-1:0] in_label_reg;
    logic               in_last_reg;

    // Region and configuration state.
    logic [DEGREE_W-1:0] degree_reg;
    logic [DEGREE_W-1:0] degree_next;
    logic [DW-1:0]       live_d_reg;
    logic [DW-1:0]       live_d_next;
    logic [CHROM_W-1:0]  region_chrom_reg;
    logic [CHROM_W-1:0]  region_chrom_next;
    logic [POS_W-1:0]    last_end_reg;
    logic [POS_W-1:0]    last_end_next;
    logic                closed_reg;
    logic                closed_next;

    // Result register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CHROM_W-1:0] out_chrom_reg;
    logic [POS_W-1:0]   out_start_reg;
    logic [POS_W-1:0]   out_end_reg;
    logic [LABEL_W-1:0] out_label_reg;
    mark_t              out_mark_reg;
    logic               out_final_reg;
    mark_t              tail_mark;

    // Chain and handshake control.
    ibm_entry_t        cell_item [NCELL];
    logic [NCELL-1:0]  cell_valid;
    logic              cell_big  [NCELL];
    ibm_cell_ctl_t     cell_ctl  [NCELL];
    ibm_entry_t        tail_item [MAX_DEGREE+1];
    ibm_entry_t        tail_sel;
    ibm_entry_t        new_item;
    ibm_flank_t        left_side  [MAX_DEGREE];
    ibm_flank_t        right_side [MAX_DEGREE];
    logic              centre_hit;
    logic [MAX_DEGREE-1:0] left_hit;
    logic [MAX_DEGREE-1:0] right_hit;

    logic [DW-1:0] d_clamp;
    logic [DW-1:0] d_eff;
    logic          win_empty;
    logic          cont;
    logic          take_new;
    logic          flush_req;
    logic          emit_fire;
    logic          can_shift;
    logic          chain_shift;
    logic          consume;

    // The register is always writable; the new degree applies at the next region start.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (int'(degree_reg) > MAX_DEGREE)
        begin
            d_clamp = DW'(MAX_DEGREE);
        end
        else
        begin
            d_clamp = DW'(degree_reg);
        end
    end

    assign win_empty = ~|cell_valid;

    // While the row is empty the degree tracks the register, so the first interval of a
    // region enters at the position that the new degree calls for.
    assign d_eff = win_empty ? d_clamp : live_d_reg;

    // The oldest interval that may still be needed sits degree cells past the center.
    for (genvar t = 0; t <= MAX_DEGREE; t++)
    begin : g_tail
        assign tail_item[t] = cell_item[MAX_DEGREE + t];
    end
    assign tail_sel = tail_item[d_eff];

    assign emit_fire = tail_sel.valid && (!out_valid_reg || result.ready);
    assign can_shift = !tail_sel.valid || emit_fire;

    assign cont = !closed_reg && (in_chrom_reg == region_chrom_reg) &&
                  (in_start_reg == last_end_reg);
    assign take_new  = in_valid_reg && (win_empty || cont);
    assign flush_req = !win_empty && (closed_reg || (in_valid_reg && !cont));

    // A shift either brings in the held interval or, while a region drains, an empty slot.
    assign chain_shift = can_shift && (take_new || flush_req);
    assign consume     = chain_shift && take_new;

    assign item.ready = !in_valid_reg || consume;

    always_comb
    begin
        new_item           = '0;
        new_item.start_pos = in_start_reg;
        new_item.end_pos   = in_end_reg;
        new_item.size      = in_end_reg - in_start_reg;
        new_item.label     = in_label_reg;
        new_item.last_tag  = in_last_reg;
        new_item.valid     = consume;
    end

    // Cell row. Cell MAX_DEGREE is the center; younger intervals sit below it and older
    // ones above it. Cells outside the current degree's span only ever hold empty slots.
    for (genvar c = 0; c < NCELL; c++)
    begin : g_cell
        ibm_entry_t prev_c;
        logic       load_c;
        logic       pass_c;
        logic       drop_c;
        logic       set_brk_c;
        logic       set_brkn_c;

        if (c == 0)
        begin : g_first
            assign prev_c = '0;
        end
        else
        begin : g_chain
            assign prev_c = cell_item[c-1];
        end

        if (c <= MAX_DEGREE)
        begin : g_young
            assign load_c = (d_eff == DW'(MAX_DEGREE - c));
            assign pass_c = (DW'(MAX_DEGREE - c) < d_eff);
        end
        else
        begin : g_old
            assign load_c = 1'b0;
            assign pass_c = (DW'(c - MAX_DEGREE) <= d_eff);
        end

        if (c >= MAX_DEGREE)
        begin : g_drop
            assign drop_c = emit_fire && (d_eff == DW'(c - MAX_DEGREE));
        end
        else
        begin : g_nodrop
            assign drop_c = 1'b0;
        end

        if (c < MAX_DEGREE)
        begin : g_right_flag
            assign set_brk_c  = 1'b0;
            assign set_brkn_c = right_hit[c];
        end
        else if (c == MAX_DEGREE)
        begin : g_centre_flag
            assign set_brk_c  = centre_hit;
            assign set_brkn_c = 1'b0;
        end
        else
        begin : g_left_flag
            assign set_brk_c  = 1'b0;
            assign set_brkn_c = left_hit[c - MAX_DEGREE - 1];
        end

        assign cell_ctl[c] = '{
            shift:    chain_shift,
            load:     load_c,
            pass:     pass_c,
            drop:     drop_c,
            set_brk:  set_brk_c,
            set_brkn: set_brkn_c
        };

        ibm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl[c]),
            .new_item    (new_item),
            .prev_item   (prev_c),
            .centre_size (cell_item[MAX_DEGREE].size),
            .cur_item    (cell_item[c]),
            .big         (cell_big[c])
        );

        assign cell_valid[c] = cell_item[c].valid;
    end

    // Flanks within degree cells of the center take part, and only around a real center.
    for (genvar k = 0; k < MAX_DEGREE; k++)
    begin : g_flank
        assign right_side[k] = '{
            en:    cell_valid[MAX_DEGREE] && cell_valid[k] &&
                   (DW'(MAX_DEGREE - k) <= d_eff),
            big:   cell_big[k],
            label: cell_item[k].label
        };
        assign left_side[k] = '{
            en:    cell_valid[MAX_DEGREE] && cell_valid[MAX_DEGREE + 1 + k] &&
                   (DW'(k + 1) <= d_eff),
            big:   cell_big[MAX_DEGREE + 1 + k],
            label: cell_item[MAX_DEGREE + 1 + k].label
        };
    end

    ibm_judge #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_judge (
        .left_side  (left_side),
        .right_side (right_side),
        .centre_hit (centre_hit),
        .left_hit   (left_hit),
        .right_hit  (right_hit)
    );

    // Break wins over broken.
    always_comb
    begin
        if (tail_sel.brk)
        begin
            tail_mark = MARK_BRK;
        end
        else if (tail_sel.brkn)
        begin
            tail_mark = MARK_BROKEN;
        end
        else
        begin
            tail_mark = MARK_NONE;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item.valid && item.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end

        degree_next = (cfg.valid && cfg.ready) ? cfg.degree : degree_reg;
        live_d_next = d_eff;

        region_chrom_next = (consume && win_empty) ? in_chrom_reg : region_chrom_reg;
        last_end_next     = consume ? in_end_reg : last_end_reg;

        // A region is closed once its final interval is in; it reopens when drained.
        if (consume)
        begin
            closed_next = in_last_reg;
        end
        else if (win_empty)
        begin
            closed_next = 1'b0;
        end
        else
        begin
            closed_next = closed_reg;
        end

        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            degree_reg       <= DEGREE_RESET;
            live_d_reg       <= '0;
            region_chrom_reg <= '0;
            closed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            degree_reg       <= degree_next;
            live_d_reg       <= live_d_next;
            region_chrom_reg <= region_chrom_next;
            closed_reg       <= closed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_end_reg <= last_end_next;
        if (item.valid && item.ready)
        begin
            in_chrom_reg <= item.chrom_id;
            in_start_reg <= item.start_pos;
            in_end_reg   <= item.end_pos;
            in_label_reg <= item.state_label;
            in_last_reg  <= item.last_item;
        end
        if (emit_fire)
        begin
            out_chrom_reg <= region_chrom_reg;
            out_start_reg <= tail_sel.start_pos;
            out_end_reg   <= tail_sel.end_pos;
            out_label_reg <= tail_sel.label;
            out_mark_reg  <= tail_mark;
            out_final_reg <= tail_sel.last_tag;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_chrom    = out_chrom_reg;
    assign result.out_start    = out_start_reg;
    assign result.out_end      = out_end_reg;
    assign result.out_label    = out_label_reg;
    assign result.mark         = out_mark_reg;
    assign result.final_result = out_final_reg;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the interval break marker unit.
`timescale 1ns / 100ps

module tb_top;
    import ibm_pkg::*;

    localparam int WIN_DEPTH   = 3 * DEF_MAX_DEGREE + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_WAIT = 2 * DEF_MAX_DEGREE + 8;

    // One interval as the sender offers it.
    typedef struct {
        logic [CHROM_W-1:0] chrom_id;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
        logic [LABEL_W-1:0] state_label;
        logic               last_item;
    } interval_t;

    // One interval as the block hands it back, with its mark.
    typedef struct {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
        logic [LABEL_W-1:0] label;
        mark_t              mark;
        logic               final_result;
    } marked_t;

    logic clk = 1'b0;
    logic rst_n;

    ibm_item_if   item_ch ();
    ibm_result_if result_ch ();
    ibm_cfg_if    cfg_ch ();

    interval_break_marker_unit #(
        .MAX_DEGREE (DEF_MAX_DEGREE)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #10 clk = ~clk;

    // Stimulus plumbing. The initial block builds a batch in plan_q and then
    // hands it over to stim_q in one go, so the driver never sees half a phase.
    interval_t plan_q[$];
    interval_t stim_q[$];
    interval_t beat_hold;
    int        queued_count   = 0;
    int        accepted_count = 0;
    bit        item_taken     = 1'b0;
    int        burst_left     = 0;
    int        gap_left       = 0;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int stall_span = 0;

    // Bookkeeping for the checker and the summary.
    marked_t expected_marks[$];
    int      fail_count    = 0;
    int      checked_count = 0;
    int      break_count   = 0;
    int      broken_count  = 0;
    int      setting_count = 1;
    int      cycle_count   = 0;

    // Shadow of the block: the pending intervals of the open region, oldest
    // first, plus the register and the degree that the open region latched.
    logic [POS_W-1:0]   win_start [WIN_DEPTH];
    logic [POS_W-1:0]   win_end   [WIN_DEPTH];
    logic [LABEL_W-1:0] win_label [WIN_DEPTH];
    mark_t              win_mark  [WIN_DEPTH];
    logic [CHROM_W-1:0] region_chrom  = '0;
    int                 win_fill      = 0;
    bit                 head_first    = 1'b0;
    int                 region_deg    = 0;
    int                 degree_shadow = int'(DEGREE_RESET);

    function automatic logic [POS_W-1:0] span_at(input int x);
        return win_end[x] - win_start[x];
    endfunction

    // Test the interval in slot center against every left/right flank pair
    // within the latched degree. Flanks are bounded by the region's first
    // slot on the left and by the newest slot on the right.
    function automatic void test_center(input int center, input int newest);
        int               lo;
        int               hi;
        logic [POS_W-1:0] sj;
        logic [POS_W-1:0] sk;
        logic [POS_W-1:0] shorter;
        lo = (center >= region_deg) ? center - region_deg : 0;
        hi = (center + region_deg < newest) ? center + region_deg : newest;
        for (int j = lo; j < center; j++)
        begin
            for (int k = center + 1; k <= hi; k++)
            begin
                sj = span_at(j);
                sk = span_at(k);
                shorter = (sj < sk) ? sj : sk;
                if (win_label[j] == win_label[k] && span_at(center) < (shorter >> 1))
                begin
                    // A break mark always wins over broken on the flanks.
                    win_mark[center] = MARK_BRK;
                    if (win_mark[j] != MARK_BRK) win_mark[j] = MARK_BROKEN;
                    if (win_mark[k] != MARK_BRK) win_mark[k] = MARK_BROKEN;
                end
            end
        end
    endfunction

    // Hand the oldest pending interval to the expectation queue.
    function automatic void release_oldest();
        marked_t res;
        res.chrom        = region_chrom;
        res.start_pos    = win_start[0];
        res.end_pos      = win_end[0];
        res.label        = win_label[0];
        res.mark         = win_mark[0];
        res.final_result = 1'b0;
        expected_marks.insert(expected_marks.size(), res);
        for (int x = 0; x + 1 < win_fill; x++)
        begin
            win_start[x] = win_start[x + 1];
            win_end[x]   = win_end[x + 1];
            win_label[x] = win_label[x + 1];
            win_mark[x]  = win_mark[x + 1];
        end
        win_fill   = win_fill - 1;
        head_first = 1'b0;
    endfunction

    // Close the open region: judge the intervals that never got a full right
    // side, leaving out the region's first and last, then release them all.
    function automatic void release_region();
        int n;
        int first;
        n = win_fill;
        if (n == 0) return;
        first = (n > region_deg) ? n - region_deg : 0;
        if (head_first && first < 1) first = 1;
        for (int i = first; i + 1 < n; i++) test_center(i, n - 1);
        while (win_fill > 0) release_oldest();
    endfunction

    // Work out every result that one accepted interval causes.
    function automatic void predict_marks(input interval_t it);
        int base_count;
        int center;
        base_count = expected_marks.size();
        if (win_fill > 0 &&
            !(it.chrom_id == region_chrom && it.start_pos == win_end[win_fill - 1]))
            release_region();
        if (win_fill == 0)
        begin
            // The degree register only takes hold when a region opens.
            region_chrom = it.chrom_id;
            head_first   = 1'b1;
            region_deg   = (degree_shadow > DEF_MAX_DEGREE) ? DEF_MAX_DEGREE : degree_shadow;
        end
        win_start[win_fill] = it.start_pos;
        win_end[win_fill]   = it.end_pos;
        win_label[win_fill] = it.state_label;
        win_mark[win_fill]  = MARK_NONE;
        win_fill            = win_fill + 1;
        if (win_fill - 1 >= region_deg)
        begin
            center = win_fill - 1 - region_deg;
            if (center >= 1 || !head_first) test_center(center, win_fill - 1);
        end
        if (win_fill == 2 * region_deg + 1) release_oldest();
        if (it.last_item)
        begin
            release_region();
            if (expected_marks.size() > base_count)
                expected_marks[expected_marks.size() - 1].final_result = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("[%0t] result %0d: %s got %0h, expected %0h",
                 $realtime, checked_count, what, got, want);
    endtask

    // Compare one result beat, field by field, with the oldest expectation.
    task automatic check_result();
        marked_t want;
        if (expected_marks.size() == 0)
        begin
            report_mismatch("result with nothing pending, start",
                            64'(result_ch.out_start), 64'd0);
            return;
        end
        want = expected_marks.pop_front();
        if (result_ch.out_chrom !== want.chrom)
            report_mismatch("out_chrom", 64'(result_ch.out_chrom), 64'(want.chrom));
        if (result_ch.out_start !== want.start_pos)
            report_mismatch("out_start", 64'(result_ch.out_start), 64'(want.start_pos));
        if (result_ch.out_end !== want.end_pos)
            report_mismatch("out_end", 64'(result_ch.out_end), 64'(want.end_pos));
        if (result_ch.out_label !== want.label)
            report_mismatch("out_label", 64'(result_ch.out_label), 64'(want.label));
        if (result_ch.mark !== want.mark)
            report_mismatch("mark", 64'(result_ch.mark), 64'(want.mark));
        if (result_ch.final_result !== want.final_result)
            report_mismatch("final_result", 64'(result_ch.final_result),
                            64'(want.final_result));
        if (want.mark == MARK_BRK) break_count++;
        if (want.mark == MARK_BROKEN) broken_count++;
        checked_count++;
    endtask

    // Monitor: everything is sampled at the rising edge, before the block's
    // own registers move. Register writes, result beats and input beats are
    // all observed here, so the shadow follows the exact acceptance order.
    always @(posedge clk)
    begin
        item_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready) degree_shadow = int'(cfg_ch.degree);
            if (result_ch.valid && result_ch.ready) check_result();
            if (item_ch.valid && item_ch.ready)
            begin
                item_taken = 1'b1;
                accepted_count++;
                predict_marks(beat_hold);
            end
        end
    end

    // Driver: works in bursts of random length separated by short random
    // gaps. A beat that is offered stays on the channel until it is taken.
    always @(negedge clk)
    begin
        logic drive_valid;
        drive_valid = item_ch.valid;
        if (!(item_ch.valid && !item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                drive_valid = 1'b0;
            end
            else if (stim_q.size() != 0)
            begin
                beat_hold   = stim_q.pop_front();
                drive_valid = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    // Now and then a long burst gives a stretch with no idling.
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                            : $urandom_range(0, 12);
                    gap_left   = $urandom_range(1, 6);
                end
            end
            else
            begin
                drive_valid = 1'b0;
            end
        end
        item_ch.valid       <= drive_valid;
        item_ch.chrom_id    <= beat_hold.chrom_id;
        item_ch.start_pos   <= beat_hold.start_pos;
        item_ch.end_pos     <= beat_hold.end_pos;
        item_ch.state_label <= beat_hold.state_label;
        item_ch.last_item   <= beat_hold.last_item;
    end

    // Receiver: switches between a few stall styles every so often, from
    // always ready to mostly stalled, so back-pressure lands at every phase
    // of a region's life, including its flush.
    always @(negedge clk)
    begin
        logic ready_next;
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 120);
        end
        else
        begin
            stall_span--;
        end
        case (stall_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = ($urandom_range(0, 3) != 0);
            2:       ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = ((stall_span % 7) > 2);
        endcase
        result_ch.ready <= ready_next;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_marks.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic plan_interval(input logic [CHROM_W-1:0] chrom,
                                 input logic [POS_W-1:0] first_pos,
                                 input logic [POS_W-1:0] last_pos,
                                 input logic [LABEL_W-1:0] label, input logic last);
        interval_t it;
        it.chrom_id    = chrom;
        it.start_pos   = first_pos;
        it.end_pos     = last_pos;
        it.state_label = label;
        it.last_item   = last;
        plan_q.insert(plan_q.size(), it);
    endtask

    // Move the planned batch to the driver in zero time.
    task automatic commit_plan();
        while (plan_q.size() != 0)
        begin
            stim_q.insert(stim_q.size(), plan_q.pop_front());
            queued_count++;
        end
    endtask

    // A well-formed region: one chromosome, each interval starting where the
    // previous one ended. Sizes mix long runs with short interruptions and a
    // few arbitrary (possibly wrapping) sizes; labels come mostly from a small
    // set so that flank labels match often.
    task automatic plan_region(input int len, input bit close_stream);
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   size;
        logic [LABEL_W-1:0] label;
        int                 pick;
        chrom = CHROM_W'($urandom_range(0, 255));
        pos   = $urandom();
        for (int n = 0; n < len; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)      size = $urandom_range(64, 4096);
            else if (pick < 9) size = $urandom_range(0, 31);
            else               size = $urandom();
            label = ($urandom_range(0, 4) != 0) ? LABEL_W'($urandom_range(0, 3))
                                                : LABEL_W'($urandom_range(0, 255));
            plan_interval(chrom, pos, pos + size, label, close_stream && (n == len - 1));
            pos = pos + size;
        end
    endtask

    // Random phase: mostly regions with random content, some stray intervals
    // that break whatever region is open. The phase always ends on a last item
    // so the block is empty before the next register write.
    task automatic plan_phase(input int target);
        int made;
        int eff_deg;
        int len;
        made    = 0;
        eff_deg = (degree_shadow > DEF_MAX_DEGREE) ? DEF_MAX_DEGREE : degree_shadow;
        while (made < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                plan_interval(CHROM_W'($urandom_range(0, 255)), $urandom(), $urandom(),
                              LABEL_W'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
                made++;
            end
            else
            begin
                len = $urandom_range(1, 2 * eff_deg + 6);
                if (len > target - made) len = target - made;
                plan_region(len, ($urandom_range(0, 3) == 0));
                made += len;
            end
        end
        plan_q[plan_q.size() - 1].last_item = 1'b1;
        commit_plan();
    endtask

    // Wait until every interval went in and every result came out, then let
    // the block finish any trailing flush shifts.
    task automatic wait_drained();
        do @(negedge clk);
        while (accepted_count != queued_count || expected_marks.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_degree(input logic [DEGREE_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.degree <= value;
        do @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        setting_count++;
    endtask

    initial
    begin
        logic [POS_W-1:0]     pos;
        logic [DEGREE_W-1:0]  degree_plan [8];
        int                   a_size [10];
        int                   a_label [10];
        rst_n                  = 1'b0;
        item_ch.valid          = 1'b0;
        item_ch.chrom_id       = '0;
        item_ch.start_pos      = '0;
        item_ch.end_pos        = '0;
        item_ch.state_label    = '0;
        item_ch.last_item      = 1'b0;
        result_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.degree          = '0;
        beat_hold              = '{default: '0};
        degree_plan            = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd6, 4'd3, 4'd5};
        a_size                 = '{100, 1, 100, 2, 100, 0, 100, 100, 100, 100};
        a_label                = '{5, 7, 5, 5, 5, 0, 5, 6, 6, 5};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, at the reset degree of four. The first region is
        // longer than a full window, so marks are settled while it streams:
        // a one-long interval between two long ones of the same label, a
        // zero-size interval, and a region edge where no right flank exists.
        pos = '0;
        for (int n = 0; n < 10; n++)
        begin
            plan_interval(8'd0, pos, pos + POS_W'(a_size[n]), LABEL_W'(a_label[n]), 1'b0);
            pos = pos + POS_W'(a_size[n]);
        end
        // A coordinate gap closes the region, then a chromosome change.
        plan_interval(8'd0, 32'd5000, 32'd5100, 8'd0, 1'b0);
        plan_interval(8'd255, 32'd5100, 32'hFFFF_FFFF, 8'd255, 1'b0);
        // Sizes that wrap past the top of the coordinate range, and an end
        // below its start, closing the stream.
        plan_interval(8'd255, 32'hFFFF_FFFF, 32'd5, 8'd255, 1'b0);
        plan_interval(8'd255, 32'd5, 32'd0, 8'd0, 1'b1);
        // A region of a single interval that is also the last one.
        plan_interval(8'd1, 32'd0, 32'd0, 8'd0, 1'b1);
        // Huge wrapped flanks around a short interval, with the stream ending
        // while the right side of the window is still short.
        plan_interval(8'd2, 32'd10, 32'd5, 8'd3, 1'b0);
        plan_interval(8'd2, 32'd5, 32'd6, 8'd1, 1'b0);
        plan_interval(8'd2, 32'd6, 32'd1, 8'd3, 1'b0);
        plan_interval(8'd2, 32'd1, 32'd2, 8'd3, 1'b0);
        plan_interval(8'd2, 32'd2, 32'd1, 8'd3, 1'b1);
        commit_plan();
        wait_drained();

        // Random phases, each under its own degree: the largest supported,
        // the smallest nonzero, zero (pass-through), a value above the maximum, and a
        // few in between.
        foreach (degree_plan[p])
        begin
            write_degree(degree_plan[p]);
            plan_phase(36);
            wait_drained();
        end

        $display("Sent %0d intervals under %0d degree settings, checked %0d results",
                 accepted_count, setting_count, checked_count);
        $display("Marks seen: %0d break, %0d broken, %0d mismatches",
                 break_count, broken_count, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
